[hdl/aad_pkg.sv]
// Shared types and constants for the averaged converter-to-distance block.
// Used by aad_sdiv and averaged_adc_to_distance; depends on nothing.
`timescale 1ns / 1ps

package aad_pkg;

    // Field widths
    localparam int CH_W       = 2;
    localparam int SAMPLE_W   = 12;
    localparam int DIST_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Serial divider: product of a 12-bit offset and a 16-bit span
    localparam int DIV_W     = SAMPLE_W + DIST_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Parameter defaults
    localparam int CHANNELS_DEF = 3;
    localparam int WINDOW_DEF   = 8;

    // Configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_AVG_EN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_FLOOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_CEIL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_CEIL  = 3'd4;

    // Configuration reset values
    localparam logic                RST_AVG_EN     = 1'b1;
    localparam logic [SAMPLE_W-1:0] RST_ADC_FLOOR  = 12'd16;
    localparam logic [SAMPLE_W-1:0] RST_ADC_CEIL   = 12'd3037;
    localparam logic [DIST_W-1:0]   RST_DIST_FLOOR = 16'd200;
    localparam logic [DIST_W-1:0]   RST_DIST_CEIL  = 16'd2500;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_MEAN,
        ST_MAP,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

[hdl/aad_sdiv.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on aad_pkg. Dividend is supplied left-aligned to nbits.
`timescale 1ns / 1ps

module aad_sdiv (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [aad_pkg::DIV_W-1:0]      dividend,
    input  logic [aad_pkg::SAMPLE_W-1:0]   divisor,
    input  logic [aad_pkg::DIV_CNT_W-1:0]  nbits,
    output logic                           busy,
    output logic [aad_pkg::DIV_W-1:0]      quotient
);
    import aad_pkg::*;

    logic                  busy_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIV_W-1:0]      quo_reg;
    logic [SAMPLE_W-1:0]   rem_reg;
    logic [SAMPLE_W-1:0]   dvs_reg;

    logic [SAMPLE_W:0]     trial;
    logic                  fits;
    logic [SAMPLE_W-1:0]   rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? SAMPLE_W'(trial - {1'b0, dvs_reg}) : trial[SAMPLE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= nbits;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[hdl/averaged_adc_to_distance.sv]
// Top level: per-channel moving average and linear converter-to-distance map.
// Depends on aad_pkg and aad_sdiv (shared bit-serial divider).
`timescale 1ns / 1ps

//  channel   direction  handshake               payload
//  s_        in         s_valid / s_ready       s_channel, s_sample
//  m_        out        m_valid / m_ready       m_reading_channel, m_reading,
//                                               m_distance_mm, m_below_floor,
//                                               m_config_fault
//  cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  One item at a time. Steps: a window update (in-range channel), the mean (averaging on),
//  a shift-add multiply over the offset bits and the span division. Faulted or
//  below-floor items skip the multiply and division. A stall on m_ holds the
//  sequencer in its last state. After reset the window memory is swept to zero with
//  s_ready low; cfg_ready is tied high. The result waits in an output register, so the
//  next transfer on s_ is taken while it still waits on m_.

module averaged_adc_to_distance #(
    parameter int CHANNELS = aad_pkg::CHANNELS_DEF,
    parameter int WINDOW   = aad_pkg::WINDOW_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [aad_pkg::CH_W-1:0]         s_channel,
    input  logic [aad_pkg::SAMPLE_W-1:0]     s_sample,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [aad_pkg::CH_W-1:0]         m_reading_channel,
    output logic [aad_pkg::SAMPLE_W-1:0]     m_reading,
    output logic [aad_pkg::DIST_W-1:0]       m_distance_mm,
    output logic                             m_below_floor,
    output logic                             m_config_fault,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aad_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import aad_pkg::*;

    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(WINDOW);
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW    = SAMPLE_W + $clog2(WINDOW);

    // Configuration
    logic                 avg_en_reg;
    logic [SAMPLE_W-1:0]  adc_floor_reg;
    logic [SAMPLE_W-1:0]  adc_ceil_reg;
    logic [DIST_W-1:0]    dist_floor_reg;
    logic [DIST_W-1:0]    dist_ceil_reg;
    logic                 fault;

    // Control
    state_t               state_reg;
    state_t               state_next;
    logic [AW-1:0]        clr_cnt_reg;

    // Item in flight
    logic [CH_W-1:0]      ch_reg;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic [SAMPLE_W-1:0]  reading_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic                 below_reg;
    logic                 in_range;
    logic [CW-1:0]        ch_idx;

    // Per-channel window state
    logic [SW-1:0]        sum_reg [CHANNELS];
    logic [PW-1:0]        ptr_reg [CHANNELS];
    logic [SW-1:0]        sum_new;

    // Window memory
    logic [SAMPLE_W-1:0]  mem [DEPTH];
    logic [SAMPLE_W-1:0]  rd_data_reg;
    logic [AW-1:0]        mem_addr;
    logic                 mem_we;
    logic [SAMPLE_W-1:0]  mem_wdata;

    // Shift-add multiplier
    logic [SAMPLE_W-1:0]  mul_a_reg;
    logic [DIV_W-1:0]     mul_b_reg;
    logic [DIV_W-1:0]     prod_reg;

    // Divider
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [SAMPLE_W-1:0]  div_divisor;
    logic [DIV_CNT_W-1:0] div_nbits;
    logic                 div_busy;
    logic [DIV_W-1:0]     div_quo;
    logic [DIV_W:0]       mapped;

    // Output register
    logic                 m_valid_reg;
    logic                 out_load;
    logic [CH_W-1:0]      m_ch_reg;
    logic [SAMPLE_W-1:0]  m_reading_reg;
    logic [DIST_W-1:0]    m_dist_reg;
    logic                 m_below_reg;
    logic                 m_fault_reg;

    assign cfg_ready = 1'b1;
    assign fault     = (adc_ceil_reg <= adc_floor_reg) || (dist_ceil_reg < dist_floor_reg);
    assign in_range  = int'(ch_reg) < CHANNELS;
    assign ch_idx    = CW'(ch_reg);
    assign sum_new   = sum_reg[ch_idx] - SW'(rd_data_reg) + SW'(sample_reg);
    assign mapped    = {1'b0, div_quo} + (DIV_W + 1)'(dist_floor_reg);

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_en_reg     <= RST_AVG_EN;
            adc_floor_reg  <= RST_ADC_FLOOR;
            adc_ceil_reg   <= RST_ADC_CEIL;
            dist_floor_reg <= RST_DIST_FLOOR;
            dist_ceil_reg  <= RST_DIST_CEIL;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_AVG_EN:     avg_en_reg     <= cfg_data[0];
                REG_ADC_FLOOR:  adc_floor_reg  <= cfg_data[SAMPLE_W-1:0];
                REG_ADC_CEIL:   adc_ceil_reg   <= cfg_data[SAMPLE_W-1:0];
                REG_DIST_FLOOR: dist_floor_reg <= cfg_data[DIST_W-1:0];
                REG_DIST_CEIL:  dist_ceil_reg  <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_cnt_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_valid) state_next = ST_READ;
            ST_READ:   state_next = in_range ? ST_UPDATE : ST_MAP;
            ST_UPDATE: state_next = avg_en_reg ? ST_MEAN : ST_MAP;
            ST_MEAN:   if (!div_busy) state_next = ST_MAP;
            ST_MAP:    state_next = (fault || (reading_reg < adc_floor_reg)) ? ST_OUT : ST_MUL;
            ST_MUL:    if (mul_a_reg == '0) state_next = ST_DIV;
            ST_DIV:    if (!div_busy) state_next = ST_OUT;
            ST_OUT:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        mem_we       = 1'b0;
        mem_wdata    = sample_reg;
        mem_addr     = AW'(ch_idx) * AW'(WINDOW) + AW'(ptr_reg[ch_idx]);
        div_start    = 1'b0;
        div_dividend = {sum_new, {(DIV_W - SW){1'b0}}};
        div_divisor  = SAMPLE_W'(WINDOW);
        div_nbits    = DIV_CNT_W'(SW);
        out_load     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                mem_addr  = clr_cnt_reg;
            end
            ST_IDLE:   s_ready = 1'b1;
            ST_UPDATE: begin
                mem_we    = 1'b1;
                div_start = avg_en_reg;
            end
            ST_MUL: begin
                // product is complete once the multiplier bits run out
                div_start    = (mul_a_reg == '0);
                div_dividend = prod_reg;
                div_divisor  = adc_ceil_reg - adc_floor_reg;
                div_nbits    = DIV_CNT_W'(DIV_W);
            end
            ST_OUT:    out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // ---------------- window memory ----------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (state_reg == ST_CLEAR) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c] <= '0;
                ptr_reg[c] <= '0;
            end
        end else if (state_reg == ST_UPDATE) begin
            sum_reg[ch_idx] <= sum_new;
            ptr_reg[ch_idx] <= (ptr_reg[ch_idx] == PW'(WINDOW - 1)) ? '0
                                                                   : ptr_reg[ch_idx] + 1'b1;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                ch_reg      <= s_channel;
                sample_reg  <= s_sample;
                reading_reg <= s_sample;    // raw sample unless the mean replaces it
            end
            ST_MEAN: begin
                if (!div_busy) begin
                    reading_reg <= div_quo[SAMPLE_W-1:0];
                end
            end
            ST_MAP: begin
                below_reg <= reading_reg < adc_floor_reg;
                dist_reg  <= fault ? dist_ceil_reg : '0;
                mul_a_reg <= reading_reg - adc_floor_reg;
                mul_b_reg <= DIV_W'(dist_ceil_reg - dist_floor_reg);
                prod_reg  <= '0;
            end
            ST_MUL: begin
                if (mul_a_reg[0]) begin
                    prod_reg <= prod_reg + mul_b_reg;
                end
                mul_a_reg <= mul_a_reg >> 1;
                mul_b_reg <= mul_b_reg << 1;
            end
            ST_DIV: begin
                if (!div_busy) begin
                    // saturate on the exact mapped value
                    dist_reg <= (mapped >= (DIV_W + 1)'(dist_ceil_reg)) ? dist_ceil_reg
                                                                       : mapped[DIST_W-1:0];
                end
            end
            default: ;
        endcase
    end

    aad_sdiv u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .nbits    (div_nbits),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_ch_reg      <= ch_reg;
            m_reading_reg <= reading_reg;
            m_dist_reg    <= dist_reg;
            m_below_reg   <= below_reg;
            m_fault_reg   <= fault;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_reading_channel = m_ch_reg;
    assign m_reading         = m_reading_reg;
    assign m_distance_mm     = m_dist_reg;
    assign m_below_floor     = m_below_reg;
    assign m_config_fault    = m_fault_reg;

endmodule

[tb/averaged_adc_to_distance_tb.sv]
// Self-checking bench for averaged_adc_to_distance: directed table, then random phases.
// Depends on aad_pkg and the averaged_adc_to_distance RTL; reads no files.
`timescale 1ns / 1ps

module averaged_adc_to_distance_tb;

    import aad_pkg::*;

    // Block configuration under test
    localparam int CHANNELS = CHANNELS_DEF;
    localparam int WINDOW   = WINDOW_DEF;

    // Run shape
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int TAIL_CYCLES     = 80;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 10;

    // Index outside the register map; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam logic [SAMPLE_W-1:0] ADC_MAX  = 12'd4095;
    localparam logic [DIST_W-1:0]   DIST_MAX = 16'd65535;

    // One result transfer on m_
    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] reading;
        logic [DIST_W-1:0]   distance;
        logic                below;
        logic                fault;
    } reading_t;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    // One row of the directed table: either a register write or a sample
    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
        logic [CH_W-1:0]      ch;
        logic [SAMPLE_W-1:0]  smp;
        bit                   typed;     // known holds a hand-written answer
        reading_t             known;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CH_W-1:0]       s_channel;
    logic [SAMPLE_W-1:0]   s_sample;
    logic                  m_valid;
    logic                  m_ready;
    logic [CH_W-1:0]       m_reading_channel;
    logic [SAMPLE_W-1:0]   m_reading;
    logic [DIST_W-1:0]     m_distance_mm;
    logic                  m_below_floor;
    logic                  m_config_fault;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    averaged_adc_to_distance #(
        .CHANNELS(CHANNELS),
        .WINDOW  (WINDOW)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_channel        (s_channel),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_reading_channel(m_reading_channel),
        .m_reading        (m_reading),
        .m_distance_mm    (m_distance_mm),
        .m_below_floor    (m_below_floor),
        .m_config_fault   (m_config_fault),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // ------------------------------------------------------------------
    // Bench copy of the block: calibration registers and per-channel windows
    // ------------------------------------------------------------------
    logic                cur_avg_en;
    logic [SAMPLE_W-1:0] cur_adc_floor;
    logic [SAMPLE_W-1:0] cur_adc_ceil;
    logic [DIST_W-1:0]   cur_dist_floor;
    logic [DIST_W-1:0]   cur_dist_ceil;

    logic [SAMPLE_W-1:0] win_store [0:CHANNELS-1][0:WINDOW-1];
    logic [14:0]         win_sum   [0:CHANNELS-1];
    int                  win_ptr   [0:CHANNELS-1];

    reading_t  pending_readings [$];    // expected results, oldest first
    stim_row_t directed_rows    [$];

    int mismatches  = 0;
    int cycle_count = 0;
    int burst_left  = 0;                // sender transfers left with no gap

    // Push the sample into its channel's window (in-range channels only), then
    // derive the reading and the calibrated distance at the current settings.
    function automatic reading_t average_and_map(input logic [CH_W-1:0] ch,
                                                 input logic [SAMPLE_W-1:0] smp);
        reading_t        r;
        int              p;
        longint unsigned num;
        longint unsigned v;
        r.channel = ch;
        r.reading = smp;
        if (ch < CHANNELS) begin
            p = win_ptr[ch];
            win_sum[ch] = win_sum[ch] - 15'(win_store[ch][p]) + 15'(smp);
            win_store[ch][p] = smp;
            win_ptr[ch] = (p + 1) % WINDOW;
            if (cur_avg_en)
                r.reading = SAMPLE_W'(win_sum[ch] / WINDOW);
        end
        r.below = (r.reading < cur_adc_floor);
        r.fault = (cur_adc_ceil <= cur_adc_floor) || (cur_dist_ceil < cur_dist_floor);
        if (r.fault) begin
            r.distance = cur_dist_ceil;
        end else if (r.below) begin
            r.distance = '0;
        end else begin
            // exact product, then saturate - the mapped value must never wrap
            num = (64'(r.reading) - 64'(cur_adc_floor)) *
                  (64'(cur_dist_ceil) - 64'(cur_dist_floor));
            v = num / (64'(cur_adc_ceil) - 64'(cur_adc_floor)) + 64'(cur_dist_floor);
            if (v >= 64'(cur_dist_ceil))
                v = 64'(cur_dist_ceil);
            r.distance = v[DIST_W-1:0];
        end
        return r;
    endfunction

    // Register writes keep only the register's own width
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_AVG_EN:     cur_avg_en     = data[0];
            REG_ADC_FLOOR:  cur_adc_floor  = data[SAMPLE_W-1:0];
            REG_ADC_CEIL:   cur_adc_ceil   = data[SAMPLE_W-1:0];
            REG_DIST_FLOOR: cur_dist_floor = data;
            REG_DIST_CEIL:  cur_dist_ceil  = data;
            default: ;
        endcase
    endfunction

    // Sender gaps: mostly none or short, a few long, plus gap-free bursts
    function automatic int pick_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            burst_left = $urandom_range(5, 30);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Samples lean on the extremes and on the area around adc_floor
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int near;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ADC_MAX;
            2, 3, 4: begin
                near = int'(cur_adc_floor) + int'($urandom_range(0, 6)) - 3;
                if (near < 0) near = 0;
                if (near > int'(ADC_MAX)) near = int'(ADC_MAX);
                return SAMPLE_W'(near);
            end
            default: return SAMPLE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Directed table builders
    function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.data  = data;
        row.ch    = '0;
        row.smp   = '0;
        row.typed = 1'b0;
        row.known = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_item(input logic [CH_W-1:0] ch,
                                     input logic [SAMPLE_W-1:0] smp);
        stim_row_t row;
        row.kind  = ROW_ITEM;
        row.idx   = '0;
        row.data  = '0;
        row.ch    = ch;
        row.smp   = smp;
        row.typed = 1'b0;
        row.known = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_known(input logic [CH_W-1:0] ch,
                                      input logic [SAMPLE_W-1:0] smp,
                                      input logic [SAMPLE_W-1:0] rd,
                                      input logic [DIST_W-1:0] mm,
                                      input logic bf,
                                      input logic cf);
        stim_row_t row;
        row.kind           = ROW_ITEM;
        row.idx            = '0;
        row.data           = '0;
        row.ch             = ch;
        row.smp            = smp;
        row.typed          = 1'b1;
        row.known.channel  = ch;
        row.known.reading  = rd;
        row.known.distance = mm;
        row.known.below    = bf;
        row.known.fault    = cf;
        directed_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Transfer tasks; each is entered and left on a rising edge
    // ------------------------------------------------------------------

    // s_valid is left high after the transfer so that a back-to-back item
    // needs only one assignment in that time step
    task automatic send_item(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                             input bit typed, input reading_t known);
        int       gap;
        reading_t pred;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_channel <= ch;
        s_sample  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // predictor always runs so its windows track the block
        pred = average_and_map(ch, smp);
        pending_readings.push_back(typed ? known : pred);
    endtask

    // Every item gives a result, so an empty queue means the block is idle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes every register; unused upper data bits carry junk that must be dropped
    task automatic write_settings(input logic avg, input logic [SAMPLE_W-1:0] af,
                                  input logic [SAMPLE_W-1:0] ac,
                                  input logic [DIST_W-1:0] df,
                                  input logic [DIST_W-1:0] dc);
        write_reg(REG_AVG_EN,     {15'($urandom_range(0, 32767)), avg});
        write_reg(REG_ADC_FLOOR,  {4'($urandom_range(0, 15)), af});
        write_reg(REG_ADC_CEIL,   {4'($urandom_range(0, 15)), ac});
        write_reg(REG_DIST_FLOOR, df);
        write_reg(REG_DIST_CEIL,  dc);
        write_reg(REG_SPARE,      CFG_DATA_W'($urandom_range(0, 65535)));
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, receiver and checker
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: ready stretches and stalls of random length
    initial begin
        int   hold;
        int   roll;
        logic rdy;
        hold    = 0;
        rdy     = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold == 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    rdy  = 1'b1;
                    hold = $urandom_range(1, 30);
                end else if (roll < 90) begin
                    rdy  = 1'b0;
                    hold = $urandom_range(1, 3);
                end else if (roll < 98) begin
                    rdy  = 1'b0;
                    hold = $urandom_range(4, 12);
                end else begin
                    rdy  = 1'b0;
                    hold = $urandom_range(20, 60);
                end
            end
            hold--;
            m_ready <= rdy;
        end
    end

    // Each result transfer is matched against the oldest expectation
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: ch %0d reading %0d dist %0d below %0b fault %0b",
                             m_reading_channel, m_reading, m_distance_mm,
                             m_below_floor, m_config_fault);
            end else begin
                want = pending_readings.pop_front();
                if (m_reading_channel !== want.channel || m_reading !== want.reading ||
                    m_distance_mm !== want.distance || m_below_floor !== want.below ||
                    m_config_fault !== want.fault) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: exp ch %0d reading %0d dist %0d below %0b fault %0b",
                                 want.channel, want.reading, want.distance, want.below,
                                 want.fault);
                        $display("          got ch %0d reading %0d dist %0d below %0b fault %0b",
                                 m_reading_channel, m_reading, m_distance_mm,
                                 m_below_floor, m_config_fault);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic                af;
        logic [SAMPLE_W-1:0] a_lo;
        logic [SAMPLE_W-1:0] a_hi;
        logic [DIST_W-1:0]   d_lo;
        logic [DIST_W-1:0]   d_hi;
        logic [CH_W-1:0]     ch;
        stim_row_t           row;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_channel = '0;
        s_sample  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // bench copy starts from the block's reset state
        cur_avg_en     = RST_AVG_EN;
        cur_adc_floor  = RST_ADC_FLOOR;
        cur_adc_ceil   = RST_ADC_CEIL;
        cur_dist_floor = RST_DIST_FLOOR;
        cur_dist_ceil  = RST_DIST_CEIL;
        for (int c = 0; c < CHANNELS; c++) begin
            for (int i = 0; i < WINDOW; i++)
                win_store[c][i] = '0;
            win_sum[c] = '0;
            win_ptr[c] = 0;
        end

        // Directed table. Reset settings first: floor 16, ceiling 3037,
        // 200 mm to 2500 mm, averaging on.
        row_known(2'd0, 12'd0,    12'd0,    16'd0,    1'b1, 1'b0); // empty window
        row_known(2'd3, ADC_MAX,  ADC_MAX,  16'd2500, 1'b0, 1'b0); // no window, saturated
        row_known(2'd3, 12'd0,    12'd0,    16'd0,    1'b1, 1'b0);
        for (int k = 0; k < 4; k++)
            row_item(2'd1, ADC_MAX);                                 // window filling up
        row_item(2'd2, 12'd2048);
        // raw samples
        row_cfg(REG_AVG_EN, 16'd0);
        row_known(2'd0, ADC_MAX,  ADC_MAX,  16'd2500, 1'b0, 1'b0);
        row_known(2'd0, 12'd16,   12'd16,   16'd200,  1'b0, 1'b0); // exactly at floor
        row_known(2'd0, 12'd15,   12'd15,   16'd0,    1'b1, 1'b0); // just below floor
        row_known(2'd0, 12'd3037, 12'd3037, 16'd2500, 1'b0, 1'b0); // exactly at ceiling
        row_item(2'd2, 12'd1);
        // widest spans
        row_cfg(REG_ADC_FLOOR,  16'd0);
        row_cfg(REG_ADC_CEIL,   16'd4095);
        row_cfg(REG_DIST_FLOOR, 16'd0);
        row_cfg(REG_DIST_CEIL,  DIST_MAX);
        row_known(2'd1, ADC_MAX,  ADC_MAX,  DIST_MAX, 1'b0, 1'b0);
        row_known(2'd1, 12'd0,    12'd0,    16'd0,    1'b0, 1'b0);
        row_item(2'd2, 12'd2730);
        // fault from an empty converter span: distance forced to the ceiling
        row_cfg(REG_ADC_FLOOR, 16'd4095);
        row_known(2'd0, 12'd0,    12'd0,    DIST_MAX, 1'b1, 1'b1);
        row_known(2'd3, ADC_MAX,  ADC_MAX,  DIST_MAX, 1'b0, 1'b1);
        // fault from an inverted distance span
        row_cfg(REG_ADC_FLOOR,  16'd0);
        row_cfg(REG_DIST_FLOOR, DIST_MAX);
        row_cfg(REG_DIST_CEIL,  16'd0);
        row_known(2'd1, 12'd100,  12'd100,  16'd0,    1'b0, 1'b1);
        // zero-width distance span is legal
        row_cfg(REG_DIST_FLOOR, 16'd0);
        row_item(2'd2, ADC_MAX);
        // one-code converter span: huge product, must saturate not wrap
        row_cfg(REG_ADC_CEIL,  16'd1);
        row_cfg(REG_DIST_CEIL, DIST_MAX);
        row_known(2'd3, ADC_MAX,  ADC_MAX,  DIST_MAX, 1'b0, 1'b0);
        row_known(2'd3, 12'd1,    12'd1,    DIST_MAX, 1'b0, 1'b0);
        row_known(2'd3, 12'd0,    12'd0,    16'd0,    1'b0, 1'b0);
        row_cfg(REG_AVG_EN, 16'd1);
        row_item(2'd0, 12'd2000);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // s_ready stays low during the post-reset sweep; send_item just waits
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_reg(row.idx, row.data);
            end else begin
                send_item(row.ch, row.smp, row.typed, row.known);
            end
        end

        // Random phases, each under its own settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            af = 1'($urandom_range(0, 1));
            if (ph == 0) begin
                af   = RST_AVG_EN;
                a_lo = RST_ADC_FLOOR;
                a_hi = RST_ADC_CEIL;
                d_lo = RST_DIST_FLOOR;
                d_hi = RST_DIST_CEIL;
            end else if (ph == 2) begin
                a_lo = '0;
                a_hi = ADC_MAX;
                d_lo = '0;
                d_hi = DIST_MAX;
            end else if (ph == 3 || $urandom_range(0, 4) == 0) begin
                // faulted settings, either span
                if ($urandom_range(0, 1)) begin
                    a_lo = SAMPLE_W'($urandom_range(1, 4095));
                    a_hi = SAMPLE_W'($urandom_range(0, a_lo));
                    d_lo = DIST_W'($urandom_range(0, 30000));
                    d_hi = DIST_W'($urandom_range(d_lo, 65535));
                end else begin
                    a_lo = SAMPLE_W'($urandom_range(0, 2000));
                    a_hi = SAMPLE_W'($urandom_range(a_lo + 1, 4095));
                    d_lo = DIST_W'($urandom_range(1, 65535));
                    d_hi = DIST_W'($urandom_range(0, d_lo - 1));
                end
            end else begin
                a_lo = SAMPLE_W'($urandom_range(0, 2000));
                a_hi = SAMPLE_W'($urandom_range(a_lo + 1, 4095));
                d_lo = DIST_W'($urandom_range(0, 30000));
                d_hi = DIST_W'($urandom_range(d_lo, 65535));
            end
            if (ph == 1)
                af = 1'b0;
            write_settings(af, a_lo, a_hi, d_lo, d_hi);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // the unused channel code now and then
                ch = ($urandom_range(0, 7) == 0) ? 2'd3 : CH_W'($urandom_range(0, CHANNELS - 1));
                send_item(ch, pick_sample(), 1'b0, '0);
            end
        end

        wait_idle();
        // anything arriving now is a stray result
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
